/* src/gat_pkg.sv */
// ----------------------------------------------------------------------------
// gat_pkg: shared definitions for the geared encoder angle tracker
// Field widths, Q16 angle constants, register indexes and reset values.
// ----------------------------------------------------------------------------
package gat_pkg;

  // Default encoder steps per turn.
  localparam int ENC_FULL_SCALE_DEF = 8191;

  // Field and port widths.
  localparam int CODE_W     = 16;
  localparam int ANGLE_W    = 48;
  localparam int SPEED_W    = 32;
  localparam int RATIO_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // Angles in Q16 degrees.
  localparam int DEG150_Q = 150 * 65536;
  localparam int DEG180_Q = 180 * 65536;
  localparam int DEG360_Q = 360 * 65536;

  // Reciprocal gear ratio after reset: ratio one.
  localparam logic [RATIO_W-1:0] RATIO_RESET = 17'h1_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REVERSE   = 2'd0,
    CFG_INV_RATIO = 2'd1,
    CFG_MULTITURN = 2'd2
  } cfg_idx_t;

endpackage

/* src/gat_if.sv */
// ----------------------------------------------------------------------------
// gat_if: stream interfaces of the angle tracker
// One interface for feedback frame words and one for result words.
// ----------------------------------------------------------------------------
interface gat_in_if;
  import gat_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CODE_W-1:0] angle_code;
  logic signed [CODE_W-1:0] speed_code;

  modport source (output valid, output angle_code, output speed_code, input ready);
  modport sink   (input valid, input angle_code, input speed_code, output ready);
endinterface

interface gat_out_if;
  import gat_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] output_angle;
  logic signed [SPEED_W-1:0] output_speed;

  modport source (output valid, output output_angle, output output_speed, input ready);
  modport sink   (input valid, input output_angle, input output_speed, output ready);
endinterface

/* src/geared_encoder_angle_tracker.sv */
// ----------------------------------------------------------------------------
// geared_encoder_angle_tracker: multi-turn output angle from encoder frames
// Scales each encoder code to Q16 degrees, unwraps the step from the last
// motor angle, scales it by the reciprocal gear ratio and accumulates or
// wraps the output angle. Speed is the speed code times the reciprocal ratio.
//
//   Channel | Dir | Handshake             | Word
//   in_ch   | in  | valid/ready           | angle_code, speed_code
//   out_ch  | out | valid/ready           | output_angle, output_speed
//   cfg_*   | in  | cfg_we (no back-pres.) | cfg_idx, cfg_wdata
//
// One word is in flight at a time: a new word is accepted only after the
// result of the last one is written. The path runs the 40-step serial angle
// divider, the 17-step serial ratio multiplier and the sequencing states.
// In wrap mode a sum beyond half a turn adds a 49-step serial modulo by 360
// and a hand-off. in_ch.ready is high whenever no word is in flight, even
// while a result waits in the output register; a stalled output holds the
// block before it writes the next result. Reset sets the state, tracked
// angles, valid flag and configuration; working registers are not reset.
// ----------------------------------------------------------------------------
module geared_encoder_angle_tracker #(
  parameter int ENCODER_FULL_SCALE = gat_pkg::ENC_FULL_SCALE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gat_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [gat_pkg::CFG_DATA_W-1:0] cfg_wdata,
  gat_in_if.sink                         in_ch,
  gat_out_if.source                      out_ch
);
  import gat_pkg::*;

  // Widths of the serial units and intermediate values.
  localparam int MDVD_W  = 40;              // code * 360 * 2^16 plus rounding
  localparam int MDVS_W  = 16;              // encoder full scale
  localparam int MOT_W   = 32;              // motor angle
  localparam int DIFF_W  = MOT_W + 2;
  localparam int DMAG_W  = MOT_W + 1;
  localparam int APROD_W = DMAG_W + RATIO_W;
  localparam int SPROD_W = CODE_W + RATIO_W;
  localparam int SCL_W   = APROD_W - 16 + 1;
  localparam int SUM_W   = ANGLE_W + 1;
  localparam int WDVS_W  = 25;              // 360 degrees in Q16
  localparam int HALF_FS = ENCODER_FULL_SCALE / 2;

  localparam logic signed [DIFF_W-1:0]  DIFF_LIM  = DIFF_W'(DEG150_Q);
  localparam logic signed [DIFF_W-1:0]  DIFF_TURN = DIFF_W'(DEG360_Q);
  localparam logic signed [SUM_W-1:0]   SUM_HALF  = SUM_W'(DEG180_Q);
  localparam logic signed [ANGLE_W-1:0] ACC_HALF  = ANGLE_W'(DEG180_Q);
  localparam logic signed [ANGLE_W-1:0] ACC_MAX   = {1'b0, {(ANGLE_W-1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ACC_MIN   = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [MOT_W-1:0]   MOT_MAX   = {1'b0, {(MOT_W-1){1'b1}}};
  localparam logic signed [MOT_W-1:0]   MOT_MIN   = {1'b1, {(MOT_W-1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_DIFF = 9'b000000100,
    S_WRAP = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_SUM  = 9'b000100000,
    S_FIX  = 9'b001000000,
    S_MOD  = 9'b010000000,
    S_OUT  = 9'b100000000
  } st_t;

  // Configuration registers.
  logic               rev_r;
  logic [RATIO_W-1:0] inv_r;
  logic               mt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_r <= 1'b0;
      inv_r <= RATIO_RESET;
      mt_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_REVERSE:   rev_r <= cfg_wdata[0];
        CFG_INV_RATIO: inv_r <= cfg_wdata[RATIO_W-1:0];
        CFG_MULTITURN: mt_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  st_t                      st_r, st_nxt;
  logic                     code_neg_r, code_neg_nxt;
  logic                     spd_neg_r, spd_neg_nxt;
  logic signed [MOT_W-1:0]  motor_r, motor_nxt;
  logic signed [MOT_W-1:0]  prev_r, prev_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;
  logic                     ang_neg_r, ang_neg_nxt;
  logic [SCL_W-1:0]         scl_r, scl_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic                     wrap_pos_r, wrap_pos_nxt;
  logic signed [ANGLE_W-1:0] acc_r, acc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [ANGLE_W-1:0] out_angle_r, out_angle_nxt;
  logic signed [SPEED_W-1:0] out_speed_r, out_speed_nxt;

  // Serial unit connections.
  logic                     in_fire;
  logic                     out_load;
  logic [CODE_W-1:0]        code_mag;
  logic [CODE_W-1:0]        spd_mag;
  logic [23:0]              code_deg;
  logic [MDVD_W-1:0]        mdiv_dvd;
  logic                     mdiv_done;
  logic [MDVD_W-1:0]        mdiv_quo;
  logic                     smul_done;
  logic [SPROD_W-1:0]       sprod;
  logic                     amul_start;
  logic [DMAG_W-1:0]        amul_mcand;
  logic                     amul_done;
  logic [APROD_W-1:0]       aprod;
  logic                     wdiv_start;
  logic [SUM_W-1:0]         wdiv_dvd;
  logic                     wdiv_done;
  logic [WDVS_W-1:0]        wrem;

  // Combinational helpers.
  logic                     mot_neg;
  logic signed [MOT_W-1:0]  motor_sat;
  logic signed [DIFF_W-1:0] diff_w;
  logic signed [DIFF_W-1:0] diff_abs;
  logic signed [SUM_W-1:0]  acc_ext;
  logic signed [SUM_W-1:0]  scl_ext;
  logic                     wrap_hi;
  logic                     wrap_lo;
  logic signed [SUM_W-1:0]  u_hi;
  logic signed [SUM_W-1:0]  u_lo;
  logic signed [ANGLE_W-1:0] rem_ext;
  logic signed [ANGLE_W-1:0] acc_mod;
  logic                     spd_neg_eff;
  logic signed [SPEED_W-1:0] speed_sat;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (st_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Magnitudes of the frame codes and the scaled angle dividend.
  assign code_mag = in_ch.angle_code[CODE_W-1] ? -in_ch.angle_code : in_ch.angle_code;
  assign spd_mag  = in_ch.speed_code[CODE_W-1] ? -in_ch.speed_code : in_ch.speed_code;
  assign code_deg = {8'b0, code_mag} * 24'd360;
  assign mdiv_dvd = {code_deg, 16'b0} + MDVD_W'(HALF_FS);

  // Motor angle with sign applied and held to 32 bits.
  assign mot_neg = code_neg_r ^ rev_r;
  always_comb begin
    if (!mot_neg) begin
      motor_sat = (mdiv_quo > MDVD_W'(MOT_MAX)) ? MOT_MAX : mdiv_quo[MOT_W-1:0];
    end else begin
      motor_sat = (mdiv_quo > {{(MDVD_W-MOT_W){1'b0}}, MOT_MIN}) ? MOT_MIN
                                                                 : -mdiv_quo[MOT_W-1:0];
    end
  end

  // Unwrap the step once by a full turn and take its magnitude.
  always_comb begin
    if (diff_r > DIFF_LIM) begin
      diff_w = diff_r - DIFF_TURN;
    end else if (diff_r < -DIFF_LIM) begin
      diff_w = diff_r + DIFF_TURN;
    end else begin
      diff_w = diff_r;
    end
    diff_abs = diff_w[DIFF_W-1] ? -diff_w : diff_w;
  end
  assign amul_mcand = diff_abs[DMAG_W-1:0];

  // Output angle sum and the half-turn fold.
  assign acc_ext = {acc_r[ANGLE_W-1], acc_r};
  assign scl_ext = {{(SUM_W-SCL_W){1'b0}}, scl_r};
  assign wrap_hi = (sum_r > SUM_HALF);
  assign wrap_lo = (sum_r < -SUM_HALF);
  assign u_hi    = sum_r - SUM_HALF;
  assign u_lo    = -SUM_HALF - sum_r;
  assign wdiv_dvd = wrap_hi ? u_hi : u_lo;

  // A zero remainder lands exactly on the half-turn edge.
  assign rem_ext = {{(ANGLE_W-WDVS_W){1'b0}}, wrem};
  always_comb begin
    if (wrem == '0) begin
      acc_mod = wrap_pos_r ? ACC_HALF : -ACC_HALF;
    end else begin
      acc_mod = wrap_pos_r ? (rem_ext - ACC_HALF) : (ACC_HALF - rem_ext);
    end
  end

  // Speed with sign applied and held to 32 bits.
  assign spd_neg_eff = spd_neg_r ^ rev_r;
  always_comb begin
    if (!spd_neg_eff) begin
      speed_sat = (sprod > SPROD_W'(MOT_MAX)) ? MOT_MAX : sprod[SPEED_W-1:0];
    end else begin
      speed_sat = (sprod > {{(SPROD_W-SPEED_W){1'b0}}, MOT_MIN}) ? MOT_MIN
                                                                 : -sprod[SPEED_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    st_nxt        = st_r;
    code_neg_nxt  = code_neg_r;
    spd_neg_nxt   = spd_neg_r;
    motor_nxt     = motor_r;
    prev_nxt      = prev_r;
    diff_nxt      = diff_r;
    ang_neg_nxt   = ang_neg_r;
    scl_nxt       = scl_r;
    sum_nxt       = sum_r;
    wrap_pos_nxt  = wrap_pos_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_angle_nxt = out_angle_r;
    out_speed_nxt = out_speed_r;
    amul_start    = 1'b0;
    wdiv_start    = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          code_neg_nxt = in_ch.angle_code[CODE_W-1];
          spd_neg_nxt  = in_ch.speed_code[CODE_W-1];
          st_nxt       = S_DIV;
        end
      end
      S_DIV: begin
        if (mdiv_done) begin
          motor_nxt = motor_sat;
          st_nxt    = S_DIFF;
        end
      end
      S_DIFF: begin
        diff_nxt = {{2{motor_r[MOT_W-1]}}, motor_r} - {{2{prev_r[MOT_W-1]}}, prev_r};
        st_nxt   = S_WRAP;
      end
      S_WRAP: begin
        ang_neg_nxt = diff_w[DIFF_W-1];
        amul_start  = 1'b1;
        st_nxt      = S_MUL;
      end
      S_MUL: begin
        if (amul_done) begin
          // Round half away from zero on the magnitude.
          scl_nxt = SCL_W'(aprod[APROD_W-1:16]) + SCL_W'(aprod[15]);
          st_nxt  = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt = ang_neg_r ? (acc_ext - scl_ext) : (acc_ext + scl_ext);
        st_nxt  = S_FIX;
      end
      S_FIX: begin
        if (mt_r) begin
          if (sum_r[SUM_W-1] != sum_r[ANGLE_W-1]) begin
            acc_nxt = sum_r[SUM_W-1] ? ACC_MIN : ACC_MAX;
          end else begin
            acc_nxt = sum_r[ANGLE_W-1:0];
          end
          st_nxt = S_OUT;
        end else if (wrap_hi || wrap_lo) begin
          wrap_pos_nxt = wrap_hi;
          wdiv_start   = 1'b1;
          st_nxt       = S_MOD;
        end else begin
          acc_nxt = sum_r[ANGLE_W-1:0];
          st_nxt  = S_OUT;
        end
      end
      S_MOD: begin
        if (wdiv_done) begin
          acc_nxt = acc_mod;
          st_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = acc_r;
          out_speed_nxt = speed_sat;
          prev_nxt      = motor_r;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and tracked angles.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      acc_r       <= '0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      acc_r       <= acc_nxt;
    end
  end

  // Working values of the word in flight and the output word.
  always_ff @(posedge clk) begin
    code_neg_r  <= code_neg_nxt;
    spd_neg_r   <= spd_neg_nxt;
    motor_r     <= motor_nxt;
    diff_r      <= diff_nxt;
    ang_neg_r   <= ang_neg_nxt;
    scl_r       <= scl_nxt;
    sum_r       <= sum_nxt;
    wrap_pos_r  <= wrap_pos_nxt;
    out_angle_r <= out_angle_nxt;
    out_speed_r <= out_speed_nxt;
  end

  // Code to motor angle: serial division by the encoder full scale.
  gat_div #(
    .DVD_W (MDVD_W),
    .DVS_W (MDVS_W)
  ) u_mdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_fire),
    .dividend  (mdiv_dvd),
    .divisor   (MDVS_W'(ENCODER_FULL_SCALE)),
    .done      (mdiv_done),
    .quotient  (mdiv_quo),
    .remainder ()
  );

  // Speed magnitude times the reciprocal ratio.
  gat_mul #(
    .MA_W (CODE_W),
    .MB_W (RATIO_W)
  ) u_smul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire),
    .mcand   (spd_mag),
    .mplier  (inv_r),
    .done    (smul_done),
    .product (sprod)
  );

  // Angle step magnitude times the reciprocal ratio.
  gat_mul #(
    .MA_W (DMAG_W),
    .MB_W (RATIO_W)
  ) u_amul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (amul_start),
    .mcand   (amul_mcand),
    .mplier  (inv_r),
    .done    (amul_done),
    .product (aprod)
  );

  // Fold into one turn: serial remainder by 360 degrees.
  gat_div #(
    .DVD_W (SUM_W),
    .DVS_W (WDVS_W)
  ) u_wdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (wdiv_start),
    .dividend  (wdiv_dvd),
    .divisor   (WDVS_W'(DEG360_Q)),
    .done      (wdiv_done),
    .quotient  (),
    .remainder (wrem)
  );

  // Output ports.
  assign in_ch.ready         = (st_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.output_angle = out_angle_r;
  assign out_ch.output_speed = out_speed_r;

  // The angle divider finishes only while the sequencer waits for it.
  a_mdiv_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    mdiv_done |-> (st_r == S_DIV))
    else $error("angle divider finished outside its wait state");

  // The speed product is ready long before the angle path needs it.
  a_smul_early: assert property (@(posedge clk) disable iff (!rst_n)
    smul_done |-> (st_r == S_DIV))
    else $error("speed multiplier finished after the angle division");

  // The fold remainder arrives only while the sequencer waits for it.
  a_wdiv_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    wdiv_done |-> (st_r == S_MOD))
    else $error("fold divider finished outside its wait state");

  // In wrap mode every written angle lies within half a turn.
  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !mt_r) |-> ((acc_r <= ACC_HALF) && (acc_r >= -ACC_HALF)))
    else $error("wrapped output angle beyond half a turn");

endmodule

/* src/gat_div.sv */
// ----------------------------------------------------------------------------
// gat_div: bit-serial restoring divider
// Shifts the dividend in one bit per cycle, MSB first, and shifts quotient
// bits into the same register. Runs DVD_W steps after start.
// ----------------------------------------------------------------------------
module gat_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   trial_sub;
  logic             ge;

  // One restoring step: bring down the next dividend bit and try the divisor.
  assign trial     = {rem_r, dvd_r[DVD_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign ge        = (trial >= {1'b0, divisor});

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
      rem_r <= ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  // Step counter; done is high in the cycle the results are final.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

/* src/gat_mul.sv */
// ----------------------------------------------------------------------------
// gat_mul: bit-serial shift-add multiplier
// Looks at one multiplier bit per cycle, LSB first, and shifts the partial
// product right. Runs MB_W steps after start.
// ----------------------------------------------------------------------------
module gat_mul #(
  parameter int MA_W = 16,
  parameter int MB_W = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [MA_W-1:0]      mcand,
  input  logic [MB_W-1:0]      mplier,
  output logic                 done,
  output logic [MA_W+MB_W-1:0] product
);

  localparam int CNT_W = $clog2(MB_W + 1);

  logic [MA_W-1:0]  a_r;
  logic [MA_W-1:0]  hi_r;
  logic [MB_W-1:0]  lo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [MA_W:0]    psum;

  // Add the multiplicand when the current multiplier bit is set.
  assign psum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, a_r} : '0);

  // Partial product shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= mcand;
      hi_r <= '0;
      lo_r <= mplier;
    end else if (cnt_r != '0) begin
      hi_r <= psum[MA_W:1];
      lo_r <= {psum[0], lo_r[MB_W-1:1]};
    end
  end

  // Step counter; done is high in the cycle the product is final.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(MB_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  assign done    = done_r;
  assign product = {hi_r, lo_r};

endmodule

/* bench/tb_geared_encoder_angle_tracker.sv */
// ----------------------------------------------------------------------------
// tb_geared_encoder_angle_tracker: self-checking bench for the angle tracker
// Streams feedback frames through the block under several register settings
// and checks every result word against an in-bench model of the unwrapping,
// gear scaling, accumulation and speed path. Both handshake sides stall at
// random, and the result side holds off once long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_geared_encoder_angle_tracker;
  import gat_pkg::*;

  // Q16 limits used by the model.
  localparam longint STEP_LIMIT = longint'(DEG150_Q);
  localparam longint HALF_TURN  = longint'(DEG180_Q);
  localparam longint FULL_TURN  = longint'(DEG360_Q);
  localparam longint ACC_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_MIN    = -ACC_MAX - 1;
  localparam longint S32_MAX    = 64'sd2147483647;
  localparam longint S32_MIN    = -S32_MAX - 1;

  typedef struct packed {
    logic signed [CODE_W-1:0] angle_code;
    logic signed [CODE_W-1:0] speed_code;
  } frame_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [SPEED_W-1:0] speed;
  } word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gat_in_if  in_ch ();
  gat_out_if out_ch ();

  geared_encoder_angle_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Frames waiting to be offered and result words waiting to arrive.
  frame_t pending_frames[$];
  word_t  expected_words[$];

  // Model state and its copy of the registers.
  longint       motor_prev;
  longint       shaft_acc;
  bit           rev_dir;
  bit [16:0]    inv_ratio;
  bit           multiturn;

  int          mismatches;
  int          frames_accepted;
  int          hold_left;
  bit          hold_done;
  int unsigned cycle_count;
  int          enc_pos;
  logic        idle_ok;

  // Random idling is switched off in one long window of the run.
  assign idle_ok = !(cycle_count >= 30000 && cycle_count < 55000);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10000000;
    $display("tb_geared_encoder_angle_tracker NOT OK");
    $finish;
  end

  // Division rounded to nearest, ties away from zero; den is positive.
  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Bring an angle into [-180, 180] by whole turns, however far out it lies.
  function automatic longint fold_half_turn(longint v);
    longint k;
    if (v > HALF_TURN) begin
      k = (v - HALF_TURN + FULL_TURN - 1) / FULL_TURN;
      v = v - k * FULL_TURN;
    end else if (v < -HALF_TURN) begin
      k = (-HALF_TURN - v + FULL_TURN - 1) / FULL_TURN;
      v = v + k * FULL_TURN;
    end
    return v;
  endfunction

  // Advance the tracker by one frame and return the word it should produce.
  function automatic word_t track_frame(frame_t f);
    longint motor;
    longint step;
    longint scaled;
    longint speed;
    word_t  w;
    motor = div_nearest(longint'($signed(f.angle_code)) * 360 * 65536,
                        longint'(ENC_FULL_SCALE_DEF));
    if (rev_dir) motor = -motor;
    motor = clamp_to(motor, S32_MIN, S32_MAX);

    // Unwrap a step that crossed the encoder seam.
    step = motor - motor_prev;
    if (step > STEP_LIMIT) step = step - FULL_TURN;
    else if (step < -STEP_LIMIT) step = step + FULL_TURN;

    scaled = div_nearest(step * longint'(inv_ratio), 65536);
    if (multiturn) shaft_acc = clamp_to(shaft_acc + scaled, ACC_MIN, ACC_MAX);
    else shaft_acc = fold_half_turn(shaft_acc + scaled);
    motor_prev = motor;

    speed = longint'($signed(f.speed_code)) * longint'(inv_ratio);
    if (rev_dir) speed = -speed;
    speed = clamp_to(speed, S32_MIN, S32_MAX);

    w.angle = shaft_acc[ANGLE_W-1:0];
    w.speed = speed[SPEED_W-1:0];
    return w;
  endfunction

  // Codes are taken modulo 2^16 as the frame carries them.
  task automatic add_frame(input int code, input int spd);
    frame_t f;
    f.angle_code = code[CODE_W-1:0];
    f.speed_code = spd[CODE_W-1:0];
    pending_frames.push_back(f);
  endtask

  // Mostly a turning encoder with random steps and seam crossings near the
  // unwrap threshold; the rest is raw noise and extreme codes.
  task automatic queue_rotation(input int count, input int drift);
    int step;
    int code;
    int spd;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        step = drift + int'($urandom_range(0, 1200)) - 600;
        enc_pos = ((enc_pos + step) % 8191 + 8191) % 8191;
        code = enc_pos;
      end else if (pick < 80) begin
        step = $urandom_range(3380, 3450);
        if ($urandom_range(0, 1)) step = -step;
        enc_pos = ((enc_pos + step) % 8191 + 8191) % 8191;
        code = enc_pos;
      end else if (pick < 92) begin
        code = $urandom;
      end else begin
        case ($urandom_range(0, 4))
          0: code = 32767;
          1: code = -32768;
          2: code = 0;
          3: code = 8191;
          default: code = -8191;
        endcase
      end
      if ($urandom_range(0, 9) < 7) spd = int'($urandom_range(0, 18000)) - 9000;
      else spd = $urandom;
      add_frame(code, spd);
    end
  endtask

  // Wait until every frame is taken and every word has come back.
  task automatic drain_words();
    while (pending_frames.size() != 0 || expected_words.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_REVERSE:   rev_dir   = val[0];
      CFG_INV_RATIO: inv_ratio = val[16:0];
      CFG_MULTITURN: multiturn = val[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(input bit rev, input int ratio, input bit mt);
    write_reg(CFG_REVERSE, CFG_DATA_W'(rev));
    write_reg(CFG_INV_RATIO, CFG_DATA_W'(ratio));
    write_reg(CFG_MULTITURN, CFG_DATA_W'(mt));
  endtask

  always @(posedge clk) begin
    if (!rst_n) cycle_count <= 0;
    else cycle_count <= cycle_count + 1;
  end

  // Frame driver: predicts each accepted word, then offers the next frame.
  always @(posedge clk) begin : drive_frames
    frame_t f;
    bit     offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        f.angle_code = in_ch.angle_code;
        f.speed_code = in_ch.speed_code;
        expected_words.push_back(track_frame(f));
        void'(pending_frames.pop_front());
        frames_accepted <= frames_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        offer = (pending_frames.size() != 0) &&
                !(idle_ok && $urandom_range(0, 99) < 21);
        in_ch.valid <= offer;
        if (offer) begin
          in_ch.angle_code <= pending_frames[0].angle_code;
          in_ch.speed_code <= pending_frames[0].speed_code;
        end
      end
    end
  end

  // One long hold-off on the result side once traffic is under way.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && frames_accepted >= 400) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  // Result monitor: compares each word with the oldest prediction.
  always @(posedge clk) begin : check_words
    word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: angle %0d speed %0d",
                     $signed(out_ch.output_angle), $signed(out_ch.output_speed));
        end else begin
          want = expected_words.pop_front();
          if (want.angle !== out_ch.output_angle || want.speed !== out_ch.output_speed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("word mismatch: angle exp %0d got %0d, speed exp %0d got %0d",
                       $signed(want.angle), $signed(out_ch.output_angle),
                       $signed(want.speed), $signed(out_ch.output_speed));
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && !(idle_ok && $urandom_range(0, 99) < 21);
    end
  end

  initial begin : run_phases
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.angle_code = '0;
    in_ch.speed_code = '0;
    out_ch.ready     = 1'b0;
    mismatches       = 0;
    frames_accepted  = 0;
    enc_pos          = 0;
    motor_prev       = 0;
    shaft_acc        = 0;
    rev_dir          = 1'b0;
    inv_ratio        = RATIO_RESET;
    multiturn        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: steps just inside and just past the unwrap threshold,
    // extreme codes and speeds, and quarter turns that push past half a turn.
    add_frame(0, 0);
    add_frame(3412, 32767);
    add_frame(6825, -32768);
    add_frame(0, 1);
    add_frame(-3413, -1);
    add_frame(32767, 0);
    add_frame(-32768, 0);
    add_frame(8191, 100);
    add_frame(0, -100);
    add_frame(1, 1);
    add_frame(-1, -1);
    add_frame(2048, 7);
    add_frame(4096, 8);
    add_frame(6144, 9);
    add_frame(0, 10);
    add_frame(2048, 11);
    add_frame(4096, 12);
    add_frame(8190, 21845);
    add_frame(-8191, -21846);
    queue_rotation(150, 0);
    drain_words();

    // Multi-turn with reversed direction and unit ratio.
    set_mode(1'b1, 65536, 1'b1);
    queue_rotation(200, 200);
    drain_words();

    // Smallest nonzero ratio.
    set_mode(1'b0, 1, 1'b1);
    queue_rotation(150, 0);
    drain_words();

    // Largest ratio the register holds, turning steadily for many turns.
    set_mode(1'b1, 131071, 1'b1);
    queue_rotation(250, 400);
    drain_words();

    // Back to wrap mode while the shaft sits many turns out.
    set_mode(1'b0, 40000, 1'b0);
    queue_rotation(200, 0);
    drain_words();

    // Zero ratio: no motion and no speed.
    set_mode(1'b0, 0, 1'b0);
    queue_rotation(100, 0);
    drain_words();

    set_mode(1'b1, 65536, 1'b0);
    queue_rotation(200, -300);
    drain_words();

    set_mode(1'($urandom_range(0, 1)), int'($urandom_range(1, 131071)),
             1'($urandom_range(0, 1)));
    queue_rotation(300, int'($urandom_range(0, 600)) - 300);
    drain_words();

    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_geared_encoder_angle_tracker OK");
    end else begin
      $display("tb_geared_encoder_angle_tracker NOT OK");
    end
    $finish;
  end

endmodule
